### hw/rtl/lsra_pkg.sv
package lsra_pkg;

  localparam int RegSlots   = 32;
  localparam int ParamSlots = 8;
  localparam int IdxW       = 5;
  localparam int CntW       = 6;

  typedef struct packed {
    logic signed [16:0] end_pos;
    logic [15:0]        vreg;
    logic [4:0]         reg_no;
  } act_entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXP_RD,
    ST_EXP_CHK,
    ST_EXP_SHIFT,
    ST_ALLOC,
    ST_EVICT_RD,
    ST_EVICT_CHK,
    ST_INS_RD,
    ST_INS_CHK,
    ST_OUT0,
    ST_OUT1
  } lsra_state_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_EXP_DROP,
    CMD_EXP_SHIFT,
    CMD_ALLOC,
    CMD_EVICT,
    CMD_INS_SHIFT,
    CMD_INS_WRITE
  } lsra_op_t;

  typedef struct packed {
    lsra_op_t    op;
    logic        cls;
    logic [IdxW-1:0] rd_addr;
    logic        rd_en;
    logic [CntW-1:0] idx;
  } lsra_cmd_t;

  typedef struct packed {
    logic [CntW-1:0] count;
    logic        exp_hit;
    logic        ins_here;
    logic        got_reg;
    logic        evict_ok;
    logic        is_float;
    logic        skip;
  } lsra_status_t;

  localparam logic [2:0] REG_INT_CNT   = 3'd0;
  localparam logic [2:0] REG_INT_TEMP  = 3'd1;
  localparam logic [2:0] REG_FP_CNT    = 3'd2;
  localparam logic [2:0] REG_FP_TEMP   = 3'd3;
  localparam logic [2:0] REG_PARAM_MAP = 3'd4;

endpackage

### hw/rtl/lsra_ctrl.sv
module lsra_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_second,
  output lsra_pkg::lsra_cmd_t  cmd,
  input  lsra_pkg::lsra_status_t sts
);
  import lsra_pkg::*;

  lsra_state_t state, state_next;
  logic [CntW-1:0] idx, idx_next;
  logic cls, cls_next;
  logic two, two_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
      cls   <= 1'b0;
      two   <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      cls   <= cls_next;
      two   <= two_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    cls_next   = cls;
    two_next   = two;
    cmd        = '0;
    cmd.op     = CMD_NONE;
    cmd.cls    = cls;
    cmd.idx    = idx;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    out_second = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op = CMD_LOAD;
          // skipped intervals only do the clearing
          if (!sts.skip) begin
            state_next = ST_EXP_RD;
            cls_next   = 1'b0;
            idx_next   = '0;
          end
        end
      end
      // expire head entries of each class, integer first
      ST_EXP_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = '0;
        state_next  = ST_EXP_CHK;
        if (sts.count == '0) begin
          if (cls) begin
            state_next = ST_ALLOC;
          end else begin
            cls_next   = 1'b1;
            state_next = ST_EXP_RD;
          end
        end
      end
      ST_EXP_CHK: begin
        if (sts.exp_hit) begin
          cmd.op     = CMD_EXP_DROP;
          idx_next   = '0;
          state_next = ST_EXP_SHIFT;
        end else if (cls) begin
          state_next = ST_ALLOC;
        end else begin
          cls_next   = 1'b1;
          state_next = ST_EXP_RD;
        end
      end
      ST_EXP_SHIFT: begin
        // move entry idx+1 down to idx, one per cycle
        if (idx + 1'b1 >= sts.count + 1'b1) begin
          state_next = ST_EXP_RD;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = IdxW'(idx + 1'b1);
          cmd.op      = CMD_EXP_SHIFT;
          idx_next    = idx + 1'b1;
        end
      end
      ST_ALLOC: begin
        cls_next = sts.is_float;
        cmd.cls  = sts.is_float;
        cmd.op   = CMD_ALLOC;
        two_next = 1'b0;
        if (sts.got_reg) begin
          idx_next   = sts.count;
          state_next = ST_INS_RD;
        end else if (sts.count != '0) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = IdxW'(sts.count - 1'b1);
          state_next  = ST_EVICT_CHK;
        end else begin
          state_next = ST_OUT0;
        end
      end
      ST_EVICT_RD: state_next = ST_EVICT_CHK;
      ST_EVICT_CHK: begin
        cmd.op = CMD_EVICT;
        if (sts.evict_ok) begin
          two_next   = 1'b1;
          idx_next   = sts.count - 1'b1;
          state_next = ST_INS_RD;
        end else begin
          state_next = ST_OUT0;
        end
      end
      // sorted insertion from the tail: idx is the hole
      ST_INS_RD: begin
        if (idx == '0) begin
          cmd.op     = CMD_INS_WRITE;
          state_next = ST_OUT0;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = IdxW'(idx - 1'b1);
          state_next  = ST_INS_CHK;
        end
      end
      ST_INS_CHK: begin
        if (sts.ins_here) begin
          cmd.op     = CMD_INS_WRITE;
          state_next = ST_OUT0;
        end else begin
          cmd.op     = CMD_INS_SHIFT;
          idx_next   = idx - 1'b1;
          state_next = ST_INS_RD;
        end
      end
      ST_OUT0: begin
        out_valid = 1'b1;
        if (!out_stall) state_next = two ? ST_OUT1 : ST_IDLE;
      end
      ST_OUT1: begin
        out_valid  = 1'b1;
        out_second = 1'b1;
        if (!out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### hw/rtl/lsra_dp.sv
module lsra_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [5:0]           int_reg_count,
  input  logic [5:0]           int_temp_count,
  input  logic [5:0]           fp_reg_count,
  input  logic [5:0]           fp_temp_count,
  input  logic [47:0]          param_map_word,
  input  logic signed [16:0]   interval_start,
  input  logic signed [16:0]   interval_end,
  input  logic [15:0]          vreg_id,
  input  logic                 is_float,
  input  logic signed [3:0]    param_hint,
  input  logic [31:0]          blocked_mask,
  input  logic                 skip,
  input  logic                 first_item,
  input  logic                 out_second,
  input  lsra_pkg::lsra_cmd_t  cmd,
  output lsra_pkg::lsra_status_t sts,
  output logic [15:0]          out_vreg_id,
  output logic [5:0]           out_reg,
  output logic                 out_spilled,
  output logic [31:0]          used_int_mask,
  output logic [31:0]          used_fp_mask
);
  import lsra_pkg::*;

  act_entry_t int_mem [RegSlots];
  act_entry_t fp_mem  [RegSlots];
  act_entry_t rd_data;
  logic [CntW-1:0] int_cnt, fp_cnt;
  logic [31:0] int_busy, fp_busy, int_used, fp_used;

  // latched transaction
  logic signed [16:0] st_pos, en_pos;
  logic [15:0] vreg;
  logic        fl;
  logic signed [3:0] hint;
  logic [31:0] blk;

  // result
  logic [4:0]  new_reg;
  logic        new_spill;
  logic [15:0] ev_vreg;
  logic        drop_pending;

  logic [CntW-1:0] cur_cnt;
  logic [31:0]     cur_busy;
  logic [5:0]      count, temp, usable;
  logic [31:0]     occ;
  logic [5:0]      hreg;
  logic            hint_ok;
  logic [5:0]      first;
  logic            found;
  logic [4:0]      found_reg;
  logic [5:0]      map_e;

  assign cur_cnt  = cmd.cls ? fp_cnt : int_cnt;
  assign cur_busy = fl ? fp_busy : int_busy;
  assign count    = fl ? fp_reg_count : int_reg_count;
  assign temp     = fl ? fp_temp_count : int_temp_count;
  assign usable   = (count < 6'(RegSlots)) ? count : 6'(RegSlots);
  assign occ      = cur_busy | blk;
  assign map_e    = param_map_word[6*hint[2:0] +: 6];

  always_comb begin
    hreg = 6'd63;
    if (!hint[3]) begin
      if (fl) hreg = {2'b00, hint};
      else if (map_e != 6'd63) hreg = map_e;
    end
    hint_ok = !hint[3] && hreg != 6'd63 && hreg < usable && !occ[hreg[4:0]];
    first   = hint[3] ? 6'd0 : temp;
    found     = 1'b0;
    found_reg = '0;
    for (int j = RegSlots - 1; j >= 0; j--) begin
      if (6'(j) >= first && 6'(j) < usable && !occ[j]) begin
        found     = 1'b1;
        found_reg = 5'(j);
      end
    end
  end

  assign sts.count    = cur_cnt;
  assign sts.exp_hit  = rd_data.end_pos <= st_pos;
  assign sts.ins_here = !(en_pos < rd_data.end_pos);
  assign sts.got_reg  = hint_ok || found;
  assign sts.evict_ok = rd_data.end_pos > en_pos;
  assign sts.is_float = fl;
  assign sts.skip     = skip;

  always_ff @(posedge clk) begin
    if (cmd.rd_en) rd_data <= cmd.cls ? fp_mem[cmd.rd_addr] : int_mem[cmd.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == CMD_EXP_SHIFT) begin
      // the entry read at idx+1 here is written down at idx through drop_pending, not here
    end
    if (cmd.op == CMD_INS_SHIFT) begin
      if (cmd.cls) fp_mem[cmd.idx[IdxW-1:0]] <= rd_data;
      else         int_mem[cmd.idx[IdxW-1:0]] <= rd_data;
    end else if (cmd.op == CMD_INS_WRITE) begin
      if (cmd.cls) fp_mem[cmd.idx[IdxW-1:0]] <= '{en_pos, vreg, new_reg};
      else         int_mem[cmd.idx[IdxW-1:0]] <= '{en_pos, vreg, new_reg};
    end else if (drop_pending) begin
      if (cmd.cls) fp_mem[cmd.idx[IdxW-1:0] - 1'b1] <= rd_data;
      else         int_mem[cmd.idx[IdxW-1:0] - 1'b1] <= rd_data;
    end
  end

  // shift write lands in the cycle after its read
  always_ff @(posedge clk) begin
    if (rst) drop_pending <= 1'b0;
    else     drop_pending <= (cmd.op == CMD_EXP_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      int_cnt  <= '0;
      fp_cnt   <= '0;
      int_busy <= '0;
      fp_busy  <= '0;
      int_used <= '0;
      fp_used  <= '0;
    end else begin
      unique case (cmd.op)
        CMD_LOAD: begin
          st_pos <= interval_start;
          en_pos <= interval_end;
          vreg   <= vreg_id;
          fl     <= is_float;
          hint   <= param_hint;
          blk    <= blocked_mask;
          if (first_item) begin
            int_cnt  <= '0;
            fp_cnt   <= '0;
            int_busy <= '0;
            fp_busy  <= '0;
            int_used <= '0;
            fp_used  <= '0;
          end
        end
        CMD_EXP_DROP: begin
          if (cmd.cls) begin
            fp_busy[rd_data.reg_no] <= 1'b0;
            fp_cnt <= fp_cnt - 1'b1;
          end else begin
            int_busy[rd_data.reg_no] <= 1'b0;
            int_cnt <= int_cnt - 1'b1;
          end
        end
        CMD_ALLOC: begin
          new_spill <= 1'b1;
          if (hint_ok || found) begin
            new_reg   <= hint_ok ? hreg[4:0] : found_reg;
            new_spill <= 1'b0;
            if (fl) begin
              fp_busy[hint_ok ? hreg[4:0] : found_reg] <= 1'b1;
              fp_used <= fp_used | fp_busy
                         | (32'd1 << (hint_ok ? hreg[4:0] : found_reg));
            end else begin
              int_busy[hint_ok ? hreg[4:0] : found_reg] <= 1'b1;
              int_used <= int_used | int_busy
                          | (32'd1 << (hint_ok ? hreg[4:0] : found_reg));
            end
          end else begin
            if (fl) fp_used <= fp_used | fp_busy;
            else    int_used <= int_used | int_busy;
          end
        end
        CMD_EVICT: begin
          if (sts.evict_ok) begin
            new_reg   <= rd_data.reg_no;
            new_spill <= 1'b0;
            ev_vreg   <= rd_data.vreg;
            if (fl) fp_cnt <= fp_cnt - 1'b1;
            else    int_cnt <= int_cnt - 1'b1;
          end
        end
        CMD_INS_WRITE: begin
          if (cmd.cls) fp_cnt <= fp_cnt + 1'b1;
          else         int_cnt <= int_cnt + 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_vreg_id   = out_second ? ev_vreg : vreg;
  assign out_reg       = (out_second || new_spill) ? count : {1'b0, new_reg};
  assign out_spilled   = out_second || new_spill;
  assign used_int_mask = int_used;
  assign used_fp_mask  = fp_used;

endmodule

### hw/rtl/linear_scan_register_allocator_unit.sv
// one interval per transaction, handled one at a time; a skipped interval gives no result
// after acceptance each class expires its head entries, integer first, moving the rest down
// then a register is chosen; with none free, the entry that ends last is evicted if it ends
// after the new one; an entry that got a register is placed by sorted insertion from the tail
// one result, or two after an eviction, each presented until taken
// synchronous active-high reset empties both active lists and clears all masks
module linear_scan_register_allocator_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [47:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [16:0]  interval_start,
  input  logic signed [16:0]  interval_end,
  input  logic [15:0]         vreg_id,
  input  logic                is_float,
  input  logic signed [3:0]   param_hint,
  input  logic [31:0]         blocked_mask,
  input  logic                skip,
  input  logic                first_item,
  input  logic                last_item,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [15:0]         out_vreg_id,
  output logic [5:0]          out_reg,
  output logic                out_spilled,
  output logic [31:0]         used_int_mask,
  output logic [31:0]         used_fp_mask,
  output logic                last_result
);
  import lsra_pkg::*;

  logic [5:0]  int_reg_count, int_temp_count, fp_reg_count, fp_temp_count;
  logic [47:0] param_map_word;
  logic        out_second;
  logic        two;
  lsra_cmd_t    cmd;
  lsra_status_t sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      int_reg_count  <= 6'd16;
      int_temp_count <= 6'd8;
      fp_reg_count   <= 6'd16;
      fp_temp_count  <= 6'd8;
      param_map_word <= '1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_INT_CNT:   int_reg_count  <= cfg_data[5:0];
        REG_INT_TEMP:  int_temp_count <= cfg_data[5:0];
        REG_FP_CNT:    fp_reg_count   <= cfg_data[5:0];
        REG_FP_TEMP:   fp_temp_count  <= cfg_data[5:0];
        REG_PARAM_MAP: param_map_word <= cfg_data;
        default: ;
      endcase
    end
  end

  // last result is the second one after an eviction, else the only one
  always_ff @(posedge clk) begin
    if (rst) two <= 1'b0;
    else if (cmd.op == CMD_ALLOC) two <= 1'b0;
    else if (cmd.op == CMD_EVICT) two <= sts.evict_ok;
  end
  assign last_result = out_second || !two;

  lsra_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
    .out_second, .cmd, .sts
  );

  lsra_dp u_dp (
    .clk, .rst, .int_reg_count, .int_temp_count, .fp_reg_count, .fp_temp_count,
    .param_map_word, .interval_start, .interval_end, .vreg_id, .is_float,
    .param_hint, .blocked_mask, .skip, .first_item, .out_second, .cmd, .sts,
    .out_vreg_id, .out_reg, .out_spilled, .used_int_mask, .used_fp_mask
  );

  logic unused_last;
  assign unused_last = last_item;

endmodule

### verif/linear_scan_register_allocator_unit_tb.sv
`timescale 1ns / 1ps

module linear_scan_register_allocator_unit_tb;
  import lsra_pkg::*;

  localparam logic [2:0] REG_UNMAPPED  = 3'd5;
  localparam int         SettleCycles  = 200;
  localparam int         Phases        = 8;
  localparam int         PhaseItems    = 140;

  typedef struct {
    logic signed [16:0] start_pos;
    logic signed [16:0] end_pos;
    logic [15:0]        vreg;
    logic               fl;
    logic signed [3:0]  hint;
    logic [31:0]        blocked;
    logic               skp;
    logic               first;
    logic               last;
    bit                 typed;
    logic [5:0]         t_reg;
    logic               t_spill;
  } interval_t;

  typedef struct {
    logic [15:0] vreg;
    logic [5:0]  phys;
    logic        spilled;
    logic [31:0] used_int;
    logic [31:0] used_fp;
    logic        last;
  } alloc_t;

  typedef struct {
    int          end_pos;
    logic [15:0] vreg;
    logic [5:0]  phys;
  } live_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [47:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [16:0] interval_start = '0;
  logic signed [16:0] interval_end = '0;
  logic [15:0] vreg_id = '0;
  logic is_float = 1'b0;
  logic signed [3:0] param_hint = '0;
  logic [31:0] blocked_mask = '0;
  logic skip = 1'b0;
  logic first_item = 1'b0;
  logic last_item = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] out_vreg_id;
  logic [5:0] out_reg;
  logic out_spilled;
  logic [31:0] used_int_mask;
  logic [31:0] used_fp_mask;
  logic last_result;

  linear_scan_register_allocator_unit u_top (.*);

  always #2 clk = ~clk;

  // predictor state, index 0 integer class, 1 floating class
  live_t       live_list [2][32];
  int          live_cnt [2];
  logic [63:0] busy_q [2];
  logic [63:0] used_q [2];
  logic [5:0]  reg_cnt [2];
  logic [5:0]  temp_cnt [2];
  logic [47:0] param_map;

  alloc_t alloc_q[$];
  int     errors = 0;

  function automatic void clear_classes();
    for (int c = 0; c < 2; c++) begin
      live_cnt[c] = 0;
      busy_q[c] = '0;
      used_q[c] = '0;
    end
  endfunction

  function automatic void expire_class(int c, int start_pos);
    int j;
    j = 0;
    while (j < live_cnt[c] && live_list[c][j].end_pos <= start_pos) begin
      busy_q[c][live_list[c][j].phys] = 1'b0;
      j++;
    end
    for (int k = j; k < live_cnt[c]; k++) live_list[c][k-j] = live_list[c][k];
    live_cnt[c] -= j;
  endfunction

  function automatic void insert_live(int c, int end_pos, logic [15:0] vreg, logic [5:0] phys);
    int j;
    j = 0;
    if (live_cnt[c] >= RegSlots) return;
    while (j < live_cnt[c] && !(end_pos < live_list[c][j].end_pos)) j++;
    for (int k = live_cnt[c]; k > j; k--) live_list[c][k] = live_list[c][k-1];
    live_list[c][j].end_pos = end_pos;
    live_list[c][j].vreg = vreg;
    live_list[c][j].phys = phys;
    live_cnt[c]++;
  endfunction

  function automatic alloc_t mk_alloc(logic [15:0] vreg, logic [5:0] phys, logic sp);
    alloc_t a;
    a.vreg = vreg;
    a.phys = phys;
    a.spilled = sp;
    a.used_int = used_q[0][31:0];
    a.used_fp = used_q[1][31:0];
    a.last = 1'b0;
    return a;
  endfunction

  function automatic void predict_alloc(interval_t it);
    int c, usable, first, regno, r, hint;
    logic [63:0] occ;
    logic [5:0] ent;
    alloc_t a0, a1;
    live_t ev;
    if (it.first) clear_classes();
    if (it.skp) return;
    expire_class(0, int'(it.start_pos));
    expire_class(1, int'(it.start_pos));
    c = it.fl ? 1 : 0;
    usable = reg_cnt[c] < RegSlots ? reg_cnt[c] : RegSlots;
    occ = busy_q[c] | {32'b0, it.blocked};
    hint = int'(it.hint);
    regno = -1;
    first = 0;
    if (hint >= 0) begin
      r = hint;
      if (!it.fl) begin
        ent = param_map[6*hint +: 6];
        r = (ent == 6'd63) ? -1 : int'(ent);
      end
      if (r >= 0 && r < usable && !occ[r]) regno = r;
      else first = temp_cnt[c];
    end
    if (regno < 0) begin
      for (int j = first; j < usable; j++) begin
        if (!occ[j]) begin
          regno = j;
          break;
        end
      end
    end
    if (regno >= 0) begin
      busy_q[c][regno] = 1'b1;
      insert_live(c, int'(it.end_pos), it.vreg, regno[5:0]);
      used_q[c] |= busy_q[c];
      a0 = mk_alloc(it.vreg, regno[5:0], 1'b0);
      a0.last = 1'b1;
    end else if (live_cnt[c] > 0 && live_list[c][live_cnt[c]-1].end_pos > int'(it.end_pos)) begin
      ev = live_list[c][live_cnt[c]-1];
      live_cnt[c]--;
      insert_live(c, int'(it.end_pos), it.vreg, ev.phys);
      used_q[c] |= busy_q[c];
      a0 = mk_alloc(it.vreg, ev.phys, 1'b0);
      a1 = mk_alloc(ev.vreg, reg_cnt[c], 1'b1);
      a1.last = 1'b1;
    end else begin
      used_q[c] |= busy_q[c];
      a0 = mk_alloc(it.vreg, reg_cnt[c], 1'b1);
      a0.last = 1'b1;
    end
    if (it.typed) begin
      a0.phys = it.t_reg;
      a0.spilled = it.t_spill;
    end
    alloc_q.push_back(a0);
    if (regno < 0 && !a0.last) alloc_q.push_back(a1);
  endfunction

  function automatic void apply_cfg(logic [2:0] idx, logic [47:0] val);
    case (idx)
      REG_INT_CNT:   reg_cnt[0] = val[5:0];
      REG_INT_TEMP:  temp_cnt[0] = val[5:0];
      REG_FP_CNT:    reg_cnt[1] = val[5:0];
      REG_FP_TEMP:   temp_cnt[1] = val[5:0];
      REG_PARAM_MAP: param_map = val;
      default: ;
    endcase
  endfunction

  // receiver: checks each taken result; stall_tick selects when a new stall pattern is drawn
  int stall_mode = 0;
  int stall_tick = 0;
  always @(posedge clk) begin
    alloc_t x;
    if (out_valid && !out_stall && !rst) begin
      if (alloc_q.size() == 0) begin
        $error("unexpected result vreg %0h", out_vreg_id);
        errors++;
      end else begin
        x = alloc_q.pop_front();
        if (out_vreg_id !== x.vreg) begin
          $error("out_vreg_id exp %0h got %0h", x.vreg, out_vreg_id); errors++;
        end
        if (out_reg !== x.phys) begin
          $error("out_reg exp %0d got %0d", x.phys, out_reg); errors++;
        end
        if (out_spilled !== x.spilled) begin
          $error("out_spilled exp %0b got %0b", x.spilled, out_spilled); errors++;
        end
        if (used_int_mask !== x.used_int) begin
          $error("used_int_mask exp %h got %h", x.used_int, used_int_mask); errors++;
        end
        if (used_fp_mask !== x.used_fp) begin
          $error("used_fp_mask exp %h got %h", x.used_fp, used_fp_mask); errors++;
        end
        if (last_result !== x.last) begin
          $error("last_result exp %0b got %0b", x.last, last_result); errors++;
        end
      end
    end
    stall_tick++;
    if (stall_tick % 64 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ((stall_tick / 8) % 2 == 1);
    endcase
  end

  int  burst_left = 0;
  bit  gaps_on = 1'b1;

  task automatic send_interval(interval_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = gaps_on ? $urandom_range(1, 8) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    interval_start <= it.start_pos;
    interval_end <= it.end_pos;
    vreg_id <= it.vreg;
    is_float <= it.fl;
    param_hint <= it.hint;
    blocked_mask <= it.blocked;
    skip <= it.skp;
    first_item <= it.first;
    last_item <= it.last;
    do @(posedge clk); while (in_stall);
    predict_alloc(it);
  endtask

  task automatic wait_drained();
    while (alloc_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_cfg(idx, val);
  endtask

  function automatic interval_t mk_row(int s, int e, int v, bit fl, int h, logic [31:0] blk,
                                       bit skp, bit first, bit typed = 0, int t_reg = 0,
                                       bit t_sp = 0);
    interval_t it;
    it.start_pos = s;
    it.end_pos = e;
    it.vreg = v;
    it.fl = fl;
    it.hint = h;
    it.blocked = blk;
    it.skp = skp;
    it.first = first;
    it.last = 1'b0;
    it.typed = typed;
    it.t_reg = t_reg;
    it.t_spill = t_sp;
    return it;
  endfunction

  function automatic int rand_pos();
    return int'($urandom_range(0, 65535)) - 1;
  endfunction

  interval_t dir_tab[$];

  initial begin
    interval_t it;
    int cur;
    logic [47:0] pm;
    reg_cnt[0] = 6'd16; temp_cnt[0] = 6'd8;
    reg_cnt[1] = 6'd16; temp_cnt[1] = 6'd8;
    param_map = 48'hFFFF_FFFF_FFFF;
    clear_classes();

    // after reset: defaults, parameter map all none
    dir_tab.push_back(mk_row(0, 10, 1, 0, -1, 0, 0, 1, 1, 0, 0));
    dir_tab.push_back(mk_row(1, 5, 2, 1, 3, 0, 0, 0, 1, 3, 0));
    // unmapped integer hint scans from the temporary count
    dir_tab.push_back(mk_row(2, 20, 3, 0, 2, 0, 0, 0, 1, 8, 0));
    // nothing free and the furthest end is shorter: new interval spilled
    dir_tab.push_back(mk_row(3, 30, 4, 0, -1, 32'hFFFF_FFFF, 0, 0, 1, 16, 1));
    // nothing free, eviction of the longer entry
    dir_tab.push_back(mk_row(4, 15, 5, 0, -1, 32'hFFFF_FFFF, 0, 0));
    dir_tab.push_back(mk_row(5, 6, 6, 1, -1, 32'h0000_FFFF, 0, 0));
    dir_tab.push_back(mk_row(6, 7, 7, 0, 7, 0, 1, 0));
    // clearing still happens with skip
    dir_tab.push_back(mk_row(7, 8, 8, 0, 0, 0, 1, 1));
    dir_tab.push_back(mk_row(-1, 65534, 16'hFFFF, 0, -1, 0, 0, 0, 1, 0, 0));
    dir_tab.push_back(mk_row(-1, -1, 0, 1, 0, 32'h0000_0001, 0, 0));
    dir_tab.push_back(mk_row(-1, 65534, 9, 1, 7, 32'h8000_0080, 0, 0));
    dir_tab.push_back(mk_row(65534, 65534, 10, 0, 7, 32'h0000_00FF, 0, 0));
    dir_tab.push_back(mk_row(65534, 65534, 11, 1, -1, 32'hFFFF_FFFF, 0, 0));
    dir_tab.push_back(mk_row(65534, 65534, 12, 1, 1, 32'hFFFF_FFFE, 0, 0));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      it = dir_tab[i];
      it.last = (i == dir_tab.size() - 1);
      send_interval(it);
    end

    for (int p = 0; p < Phases; p++) begin
      in_valid <= 1'b0;
      burst_left = 0;
      @(posedge clk);
      wait_drained();
      repeat (SettleCycles) @(posedge clk);
      pm = {$urandom(), $urandom()};
      for (int k = 0; k < 8; k++) begin
        if ($urandom_range(0, 3) == 0) pm[6*k +: 6] = 6'd63;
        else if ($urandom_range(0, 1) == 0) pm[6*k +: 6] = $urandom_range(0, 15);
      end
      case (p)
        0: begin
          write_reg(REG_INT_CNT, 48'd32); write_reg(REG_INT_TEMP, 48'd0);
          write_reg(REG_FP_CNT, 48'd1); write_reg(REG_FP_TEMP, 48'd32);
          write_reg(REG_PARAM_MAP, 48'h0);
        end
        1: begin
          write_reg(REG_INT_CNT, 48'd1); write_reg(REG_INT_TEMP, 48'd32);
          write_reg(REG_FP_CNT, 48'd32); write_reg(REG_FP_TEMP, 48'd0);
          write_reg(REG_PARAM_MAP, 48'hFFFF_FFFF_FFFF);
          write_reg(REG_UNMAPPED, {$urandom(), $urandom()});
        end
        2: begin
          // counts above the slot count
          write_reg(REG_INT_CNT, 48'd40); write_reg(REG_INT_TEMP, 48'd5);
          write_reg(REG_FP_CNT, 48'd63); write_reg(REG_FP_TEMP, 48'd2);
          write_reg(REG_PARAM_MAP, pm);
        end
        default: begin
          write_reg(REG_INT_CNT, $urandom_range(1, 8));
          write_reg(REG_INT_TEMP, $urandom_range(0, 8));
          write_reg(REG_FP_CNT, $urandom_range(1, 32));
          write_reg(REG_FP_TEMP, $urandom_range(0, 32));
          write_reg(REG_PARAM_MAP, pm);
        end
      endcase
      cfg_valid <= 1'b0;
      gaps_on = (p != 3);
      cur = ($urandom_range(0, 1) == 0) ? -1 : 0;
      for (int n = 0; n < PhaseItems; n++) begin
        if (p == 4 && n == PhaseItems / 2) begin
          in_valid <= 1'b0;
          @(posedge clk);
          wait_drained();
          burst_left = 0;
        end
        if ($urandom_range(0, 49) == 0) cur += $urandom_range(0, 20000);
        else cur += $urandom_range(0, 3);
        it = mk_row(cur, 0, $urandom_range(0, 65535), $urandom_range(0, 1),
                    ($urandom_range(0, 1) == 0) ? -1 : $urandom_range(0, 7), 0,
                    ($urandom_range(0, 19) == 0), (n == 0) || ($urandom_range(0, 49) == 0));
        if (cur > 65534) begin
          cur = 0;
          it.start_pos = 0;
          it.first = 1'b1;
        end
        it.end_pos = (cur + int'($urandom_range(0, 40)) > 65534) ? 65534
                     : cur + $urandom_range(0, 40);
        case ($urandom_range(0, 9))
          0: it.blocked = $urandom();
          1, 2: it.blocked = 32'h1 << $urandom_range(0, 31);
          3: it.blocked = ~(32'h1 << $urandom_range(0, 31));
          default: it.blocked = '0;
        endcase
        // noise: unordered positions
        if ($urandom_range(0, 11) == 0) begin
          it.start_pos = rand_pos();
          it.end_pos = rand_pos();
        end
        it.last = (n == PhaseItems - 1);
        send_interval(it);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    if (errors == 0 && alloc_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
